// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the cache top file. Each use is one labeled
// concurrent assertion, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every edge
`define ASSERT_ON_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/sactl_pkg.sv =====
// ----------------------------------------------------------------------------
// sactl_pkg
// Widths, register codes, reset values and the LFSR step of the cache tag
// lookup block.
// ----------------------------------------------------------------------------
package sactl_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int SET_IDX_W  = 6;
    localparam int WAY_OUT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam int OFFSET_W   = 4;
    localparam int INDEX_W    = 3;
    localparam int WAYS_W     = 4;
    localparam int POLICY_W   = 2;

    localparam int MAX_OFFSET_BITS = 12;
    localparam int MAX_INDEX_BITS  = 6;
    localparam int RAW_SETS        = 1 << MAX_INDEX_BITS;

    localparam int DEF_NUM_SETS = 64;
    localparam int DEF_NUM_WAYS = 8;

    localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS = 4'd6;
    localparam logic [INDEX_W-1:0]  RST_INDEX_BITS  = 3'd6;
    localparam logic [WAYS_W-1:0]   RST_WAYS_IN_USE = 4'd4;

    localparam int             LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // remainder unit: bits folded per cycle and steps per value
    localparam int MOD_DIGIT = 8;
    localparam int MOD_STEPS = LFSR_W / MOD_DIGIT;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS    = 3'd0,
        CFG_INDEX_BITS     = 3'd1,
        CFG_WAYS_IN_USE    = 3'd2,
        CFG_REPLACE_POLICY = 3'd3,
        CFG_WRITE_POLICY   = 3'd4
    } cfg_reg_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIFO   = 2'd0,
        POL_LRU    = 2'd1,
        POL_RANDOM = 2'd2
    } policy_t;

    typedef enum logic {
        WP_ALLOCATE    = 1'b0,
        WP_NO_ALLOCATE = 1'b1
    } write_policy_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    // Fibonacci LFSR, taps 16,14,13,11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[LFSR_W-1:1]};
    endfunction

endpackage

// ===== rtl/set_assoc_cache_tag_lookup_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top
// Tag store of a set-associative cache with FIFO, LRU or random replacement.
//
// Usage:
//   s_ channel: one transfer per access (s_op read/write, s_address).
//   m_ channel: one result transfer per access (hit, set, tag, allocated, way).
//   cfg_ channel: register writes (cfg_index, cfg_data); the user writes only while idle, not enforced by the block.
// Result path: the set read, then the lookup registers, then the result
//   loaded into the output register on the update, with m_valid raised.
// Accesses: the next transfer is taken on the same edge that writes the set
//   back, so the set memories' read-modify-write turn sets the rate.
//   Same-set back-to-back accesses are forwarded.
//   A random eviction waits for the victim remainder unit, which restarts
//   on every random eviction and every ways_in_use write, so a random
//   eviction right behind another one waits for the restarted remainder.
// Reset: a clearing pass over all NUM_SETS sets zeroes fill counts and stamps;
//   s_ready stays low meanwhile, cfg writes are still taken.
// Stall: a result not taken holds in the output register; the next access
//   may be accepted and looked up, but its update waits with s_ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_cache_tag_lookup_top #(
    parameter int NUM_SETS = sactl_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS = sactl_pkg::DEF_NUM_WAYS
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sactl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sactl_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [sactl_pkg::ADDR_W-1:0]     s_address,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [sactl_pkg::SET_IDX_W-1:0]  m_set_index,
    output logic [sactl_pkg::TAG_W-1:0]      m_tag,
    output logic                             m_allocated,
    output logic [sactl_pkg::WAY_OUT_W-1:0]  m_way
);
    import sactl_pkg::*;

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WCNT_W  = $clog2(NUM_WAYS + 1);
    localparam int TROW_W  = NUM_WAYS * TAG_W;
    localparam int SROW_W  = NUM_WAYS * STAMP_W;
    localparam int META_W  = SROW_W + WCNT_W;
    localparam int NGRP    = (NUM_WAYS + 3) / 4;
    localparam int NPAD    = NGRP * 4;
    localparam int MCNT_W  = $clog2(MOD_STEPS + 1);

    // LRU candidate: one way's stamp, tagged with its way number
    typedef struct packed {
        logic               vld;
        logic [STAMP_W-1:0] stamp;
        logic [WAY_W-1:0]   idx;
    } lru_cand_t;

    // smaller stamp wins, ties keep the lower way (left operand)
    function automatic lru_cand_t lru_min2(input lru_cand_t a, input lru_cand_t b);
        lru_cand_t r;
        r = a;
        if (!a.vld || (b.vld && (b.stamp < a.stamp))) begin
            r = b;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg;
    logic                  cfg_ready_reg;

    logic [OFFSET_W-1:0]   offset_bits_reg;
    logic [INDEX_W-1:0]    index_bits_reg;
    logic [WAYS_W-1:0]     ways_in_use_reg;
    logic [POLICY_W-1:0]   replace_policy_reg;
    logic                  write_policy_reg;

    logic [STAMP_W-1:0]    access_clock_reg;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic [LFSR_W-1:0]     mod_src_reg;
    logic [WCNT_W-1:0]     mod_r_reg;
    logic [MCNT_W-1:0]     mod_cnt_reg;

    logic                  op_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [SET_W-1:0]      set_reg;
    logic                  fwd_sel_reg;
    logic [TROW_W-1:0]     tag_fwd_reg;
    logic [META_W-1:0]     meta_fwd_reg;

    logic                  hit_reg;
    logic [WAY_W-1:0]      hit_way_reg;
    lru_cand_t             grp_reg [NGRP];

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [SET_IDX_W-1:0]  m_set_index_reg;
    logic [TAG_W-1:0]      m_tag_reg;
    logic                  m_allocated_reg;
    logic [WAY_OUT_W-1:0]  m_way_reg;

    // ------------------------------------------------------------------
    // Effective configuration (out-of-range values clamp)
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0]   ob_eff;
    logic [INDEX_W-1:0]    ib_eff;
    logic [WAYS_W:0]       ways_clamp;
    logic [WCNT_W-1:0]     ways_eff;

    always_comb begin
        ob_eff = (offset_bits_reg > OFFSET_W'(MAX_OFFSET_BITS)) ?
                 OFFSET_W'(MAX_OFFSET_BITS) : offset_bits_reg;
        ib_eff = (index_bits_reg > INDEX_W'(MAX_INDEX_BITS)) ?
                 INDEX_W'(MAX_INDEX_BITS) : index_bits_reg;
        ways_clamp = {1'b0, ways_in_use_reg};
        if (ways_clamp == '0) begin
            ways_clamp = (WAYS_W+1)'(1);
        end else if (ways_clamp > (WAYS_W+1)'(NUM_WAYS)) begin
            ways_clamp = (WAYS_W+1)'(NUM_WAYS);
        end
        ways_eff = WCNT_W'(ways_clamp);
    end

    // ------------------------------------------------------------------
    // Address split on the input transfer
    // ------------------------------------------------------------------
    logic                  s_acc;
    logic [4:0]            shamt;
    logic [TAG_W-1:0]      tag_in;
    logic [SET_IDX_W-1:0]  idx_mask;
    logic [SET_IDX_W-1:0]  raw_set_in;
    logic [SET_W-1:0]      set_in;
    logic [SET_W-1:0]      set_lut [RAW_SETS];

    // raw set number folded onto the sets that exist
    for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_lut
        assign set_lut[g] = SET_W'(g % NUM_SETS);
    end

    assign s_acc      = s_valid && s_ready;
    assign shamt      = {1'b0, ob_eff} + {2'b00, ib_eff};
    assign tag_in     = s_address >> shamt;
    assign idx_mask   = SET_IDX_W'((7'd1 << ib_eff) - 7'd1);
    assign raw_set_in = SET_IDX_W'(s_address >> ob_eff) & idx_mask;
    assign set_in     = set_lut[raw_set_in];

    // ------------------------------------------------------------------
    // Set memories: tags, and {fill count, stamps}
    // ------------------------------------------------------------------
    logic                  upd_go;
    logic [TROW_W-1:0]     tag_q, tag_row, tag_wdata;
    logic [META_W-1:0]     meta_q, meta_row, meta_wdata;
    logic                  meta_we;
    logic [SET_W-1:0]      meta_waddr;
    logic [META_W-1:0]     meta_wdin;

    assign meta_we    = (state_reg == S_CLEAR) || upd_go;
    assign meta_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : set_reg;
    assign meta_wdin  = (state_reg == S_CLEAR) ? '0 : meta_wdata;

    sactl_ram #(
        .WIDTH (TROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (upd_go),
        .wr_addr (set_reg),
        .wr_data (tag_wdata),
        .rd_en   (s_acc),
        .rd_addr (set_in),
        .rd_data (tag_q)
    );

    sactl_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SETS)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdin),
        .rd_en   (s_acc),
        .rd_addr (set_in),
        .rd_data (meta_q)
    );

    // same set read on the write-back edge: take the row just written
    assign tag_row  = fwd_sel_reg ? tag_fwd_reg  : tag_q;
    assign meta_row = fwd_sel_reg ? meta_fwd_reg : meta_q;

    logic [TAG_W-1:0]      tags_cur   [NUM_WAYS];
    logic [STAMP_W-1:0]    stamps_cur [NUM_WAYS];
    logic [WCNT_W-1:0]     fill_cur;

    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            tags_cur[i]   = tag_row[i*TAG_W +: TAG_W];
            stamps_cur[i] = meta_row[i*STAMP_W +: STAMP_W];
        end
        fill_cur = meta_row[SROW_W +: WCNT_W];
    end

    // ------------------------------------------------------------------
    // Lookup cycle: tag compare and first level of the LRU tree
    // ------------------------------------------------------------------
    logic [WCNT_W-1:0]     searchn;
    logic                  hit_any;
    logic [WAY_W-1:0]      hit_idx;
    lru_cand_t             cand [NPAD];
    lru_cand_t             grp_next [NGRP];

    always_comb begin
        searchn = (fill_cur < ways_eff) ? fill_cur : ways_eff;
        hit_any = 1'b0;
        hit_idx = '0;
        // descending so the lowest matching way wins
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if ((WCNT_W'(i) < searchn) && (tags_cur[i] == tag_reg)) begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(i);
            end
        end
    end

    for (genvar g = 0; g < NPAD; g++) begin : g_cand
        if (g < NUM_WAYS) begin : g_used
            assign cand[g] = '{vld:   (WCNT_W'(g) < ways_eff),
                               stamp: stamps_cur[g],
                               idx:   WAY_W'(g)};
        end else begin : g_pad
            assign cand[g] = '0;
        end
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        assign grp_next[g] = lru_min2(lru_min2(cand[4*g],     cand[4*g + 1]),
                                      lru_min2(cand[4*g + 2], cand[4*g + 3]));
    end

    // ------------------------------------------------------------------
    // Update cycle: victim choice and row rewrite
    // ------------------------------------------------------------------
    lru_cand_t             lru_best;
    logic                  full;
    logic                  alloc_req;
    logic                  rand_evict;
    logic                  alloc;
    logic [WAY_W-1:0]      way_sel;
    logic [WCNT_W-1:0]     fill_new;
    logic [STAMP_W-1:0]    clock_inc;
    logic [TAG_W-1:0]      tags_new   [NUM_WAYS];
    logic [STAMP_W-1:0]    stamps_new [NUM_WAYS];
    logic                  mod_done;
    logic                  out_free;

    always_comb begin
        lru_best = grp_reg[0];
        for (int g = 1; g < NGRP; g++) begin
            lru_best = lru_min2(lru_best, grp_reg[g]);
        end

        full       = (fill_cur >= ways_eff);
        clock_inc  = access_clock_reg + STAMP_W'(1);
        alloc_req  = !hit_reg && !((op_reg == OP_WRITE) &&
                                   (write_policy_reg == WP_NO_ALLOCATE));
        rand_evict = alloc_req && full && (replace_policy_reg == POL_RANDOM);

        alloc      = 1'b0;
        way_sel    = '0;
        fill_new   = fill_cur;
        tags_new   = tags_cur;
        stamps_new = stamps_cur;

        if (hit_reg) begin
            way_sel = hit_way_reg;
            stamps_new[hit_way_reg] = clock_inc;
        end else if (alloc_req) begin
            if (!full) begin
                way_sel  = WAY_W'(fill_cur);
                alloc    = 1'b1;
                fill_new = fill_cur + WCNT_W'(1);
            end else begin
                unique case (replace_policy_reg)
                    POL_FIFO: begin
                        // oldest entry drops out of way 0, the rest move down
                        for (int i = 0; i < NUM_WAYS - 1; i++) begin
                            if (WCNT_W'(i + 1) < ways_eff) begin
                                tags_new[i]   = tags_cur[i + 1];
                                stamps_new[i] = stamps_cur[i + 1];
                            end
                        end
                        way_sel = WAY_W'(ways_eff - WCNT_W'(1));
                        alloc   = 1'b1;
                    end
                    POL_LRU: begin
                        way_sel = lru_best.idx;
                        alloc   = 1'b1;
                    end
                    POL_RANDOM: begin
                        way_sel = WAY_W'(mod_r_reg);
                        alloc   = 1'b1;
                    end
                    default: begin
                        // unused policy code: nothing allocated
                    end
                endcase
            end
            if (alloc) begin
                tags_new[way_sel]   = tag_reg;
                stamps_new[way_sel] = clock_inc;
            end
        end

        for (int i = 0; i < NUM_WAYS; i++) begin
            tag_wdata[i*TAG_W +: TAG_W]      = tags_new[i];
            meta_wdata[i*STAMP_W +: STAMP_W] = stamps_new[i];
        end
        meta_wdata[SROW_W +: WCNT_W] = fill_new;
    end

    assign mod_done = (mod_cnt_reg == MCNT_W'(MOD_STEPS));
    assign out_free = !m_valid_reg || m_ready;
    assign upd_go   = (state_reg == S_UPDATE) && out_free && !(rand_evict && !mod_done);

    // ------------------------------------------------------------------
    // Remainder unit: next LFSR value mod ways, MOD_DIGIT bits per cycle
    // ------------------------------------------------------------------
    logic [WCNT_W-1:0]     mod_r_step;

    always_comb begin
        logic [WCNT_W:0] t;
        mod_r_step = mod_r_reg;
        for (int k = 0; k < MOD_DIGIT; k++) begin
            t = {mod_r_step, mod_src_reg[LFSR_W-1-k]};
            if (t >= {1'b0, ways_eff}) begin
                t = t - {1'b0, ways_eff};
            end
            mod_r_step = t[WCNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (upd_go) begin
                    state_next = s_acc ? S_LOOKUP : S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_CLEAR;
            clr_cnt_reg        <= '0;
            cfg_ready_reg      <= 1'b0;
            offset_bits_reg    <= RST_OFFSET_BITS;
            index_bits_reg     <= RST_INDEX_BITS;
            ways_in_use_reg    <= RST_WAYS_IN_USE;
            replace_policy_reg <= POL_LRU;
            write_policy_reg   <= WP_ALLOCATE;
            access_clock_reg   <= '0;
            lfsr_reg           <= LFSR_SEED;
            mod_src_reg        <= lfsr_step(LFSR_SEED);
            mod_r_reg          <= '0;
            mod_cnt_reg        <= '0;
            fwd_sel_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cfg_ready_reg <= 1'b1;

            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end

            if (cfg_valid && cfg_ready_reg) begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data[OFFSET_W-1:0];
                    CFG_INDEX_BITS:     index_bits_reg     <= cfg_data[INDEX_W-1:0];
                    CFG_WAYS_IN_USE:    ways_in_use_reg    <= cfg_data[WAYS_W-1:0];
                    CFG_REPLACE_POLICY: replace_policy_reg <= cfg_data[POLICY_W-1:0];
                    CFG_WRITE_POLICY:   write_policy_reg   <= cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // remainder restarts when the LFSR moves or the way count changes
            priority if (upd_go && rand_evict) begin
                lfsr_reg    <= lfsr_step(lfsr_reg);
                mod_src_reg <= lfsr_step(lfsr_step(lfsr_reg));
                mod_r_reg   <= '0;
                mod_cnt_reg <= '0;
            end else if (cfg_valid && cfg_ready_reg && (cfg_index == CFG_WAYS_IN_USE)) begin
                mod_src_reg <= lfsr_step(lfsr_reg);
                mod_r_reg   <= '0;
                mod_cnt_reg <= '0;
            end else if (!mod_done) begin
                mod_src_reg <= mod_src_reg << MOD_DIGIT;
                mod_r_reg   <= mod_r_step;
                mod_cnt_reg <= mod_cnt_reg + MCNT_W'(1);
            end else begin
                // remainder ready, held until the next restart
            end

            if (upd_go) begin
                access_clock_reg <= clock_inc;
            end

            if (s_acc) begin
                fwd_sel_reg <= (state_reg == S_UPDATE) && (set_in == set_reg);
            end

            if (upd_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg  <= s_op;
            tag_reg <= tag_in;
            set_reg <= set_in;
        end
        if (state_reg == S_LOOKUP) begin
            hit_reg     <= hit_any;
            hit_way_reg <= hit_idx;
            grp_reg     <= grp_next;
        end
        if (upd_go) begin
            tag_fwd_reg     <= tag_wdata;
            meta_fwd_reg    <= meta_wdata;
            m_hit_reg       <= hit_reg;
            m_set_index_reg <= SET_IDX_W'(set_reg);
            m_tag_reg       <= tag_reg;
            m_allocated_reg <= alloc;
            m_way_reg       <= (hit_reg || alloc) ? WAY_OUT_W'(way_sel) : '0;
        end
    end

    assign cfg_ready   = cfg_ready_reg;
    assign s_ready     = (state_reg == S_IDLE) || upd_go;
    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_set_index = m_set_index_reg;
    assign m_tag       = m_tag_reg;
    assign m_allocated = m_allocated_reg;
    assign m_way       = m_way_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_acc_to_lookup, aclk, aresetn, s_valid && s_ready,
                 state_reg == S_LOOKUP, "input transfer did not start a lookup")
    `ASSERT_NEXT(a_update_loads_out, aclk, aresetn, upd_go, m_valid,
                 "write-back did not present a result")
    `ASSERT_IMPL(a_rand_victim, aclk, aresetn, upd_go && rand_evict,
                 mod_done && (mod_r_reg < ways_eff), "random victim not ready or out of range")
    `ASSERT_IMPL(a_fill_bound, aclk, aresetn, state_reg == S_UPDATE,
                 (fill_new <= ways_eff) || (fill_new == fill_cur), "fill count overran ways")

endmodule

// ===== rtl/sactl_ram.sv =====
// ----------------------------------------------------------------------------
// sactl_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sactl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== dv/set_assoc_cache_tag_lookup_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top_test
// Self-checking bench for the cache tag lookup block. A scoreboard object keeps
// its own copy of the tag, stamp and fill state and predicts every access.
// Nine register settings are run, from the reset values to the clamped and
// reserved codes. Passes 0, 2 and 3 open with hand-picked accesses; every pass
// then runs random accesses drawn mostly from a small tag/set pool so that sets
// fill, hit and evict. Both sides idle at random in the first six passes, and
// one long receiver hold backs up the pipeline.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_top_test;
    import sactl_pkg::*;

    localparam int NSETS           = DEF_NUM_SETS;
    localparam int NWAYS           = DEF_NUM_WAYS;
    localparam int PHASES          = 9;
    localparam int RANDOM_PER_PASS = 67;
    localparam int LONG_HOLD       = 60;
    localparam int IDLE_LIMIT      = 4000;
    localparam int SHOWN_MAX       = 10;
    localparam int HOLD_PASS       = 6;

    // policy code left out of the package enum; a full-set miss allocates nothing
    localparam logic [POLICY_W-1:0]  POL_RESERVED   = 2'd3;
    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic                 hit;
        logic [SET_IDX_W-1:0] set_index;
        logic [TAG_W-1:0]     tag;
        logic                 alloc;
        logic [WAY_OUT_W-1:0] way;
    } lookup_result_t;

    typedef struct {
        logic [OFFSET_W-1:0] offset_bits;
        logic [INDEX_W-1:0]  index_bits;
        logic [WAYS_W-1:0]   ways;
        logic [POLICY_W-1:0] policy;
        logic                wpol;
    } cache_cfg_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow tag store plus the queue of predicted lookups
    // ------------------------------------------------------------------------
    class tag_lookup_scoreboard;
        logic [TAG_W-1:0]    tags   [NSETS*NWAYS];
        logic [STAMP_W-1:0]  stamps [NSETS*NWAYS];
        logic [WAYS_W-1:0]   fill_cnt [NSETS];
        logic [STAMP_W-1:0]  access_count;
        logic [LFSR_W-1:0]   lfsr_state;
        logic [OFFSET_W-1:0] offset_cfg;
        logic [INDEX_W-1:0]  index_cfg;
        logic [WAYS_W-1:0]   ways_cfg;
        logic [POLICY_W-1:0] replace_cfg;
        logic                wp_cfg;
        lookup_result_t      expected_lookups [$];
        int                  errors;

        function new();
            foreach (tags[i]) begin
                tags[i]   = '0;
                stamps[i] = '0;
            end
            foreach (fill_cnt[i]) fill_cnt[i] = '0;
            access_count = '0;
            lfsr_state   = LFSR_SEED;
            offset_cfg   = RST_OFFSET_BITS;
            index_cfg    = RST_INDEX_BITS;
            ways_cfg     = RST_WAYS_IN_USE;
            replace_cfg  = POL_LRU;
            wp_cfg       = WP_ALLOCATE;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET_BITS:    offset_cfg  = data;
                CFG_INDEX_BITS:     index_cfg   = data[INDEX_W-1:0];
                CFG_WAYS_IN_USE:    ways_cfg    = data;
                CFG_REPLACE_POLICY: replace_cfg = data[POLICY_W-1:0];
                CFG_WRITE_POLICY:   wp_cfg      = data[0];
                default: ;
            endcase
        endfunction

        function lookup_result_t predict_access(logic op, logic [ADDR_W-1:0] addr);
            int ob, ib, ways, set, base, fill, search_n, way, i;
            logic [STAMP_W-1:0] oldest;
            lookup_result_t r;
            ob   = (offset_cfg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_cfg;
            ib   = (index_cfg > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_cfg;
            ways = (ways_cfg == 0) ? 1 : ((ways_cfg > NWAYS) ? NWAYS : ways_cfg);
            access_count = access_count + 1;
            r        = '0;
            way      = 0;
            r.tag    = addr >> (ob + ib);
            set      = ((addr >> ob) & ((32'd1 << ib) - 32'd1)) % NSETS;
            base     = set * NWAYS;
            fill     = fill_cnt[set];
            search_n = (fill < ways) ? fill : ways;

            for (i = 0; i < search_n; i++) begin
                if (!r.hit && tags[base+i] == r.tag) begin
                    r.hit          = 1'b1;
                    way            = i;
                    stamps[base+i] = access_count;
                end
            end

            // no-allocate write misses leave the set alone
            if (!r.hit && !(op == OP_WRITE && wp_cfg == WP_NO_ALLOCATE)) begin
                if (fill < ways) begin
                    way           = fill;
                    r.alloc       = 1'b1;
                    fill_cnt[set] = WAYS_W'(fill + 1);
                end else if (replace_cfg == POL_FIFO) begin
                    // oldest entry drops out of way 0, newest goes in the top way
                    for (i = 0; i + 1 < ways; i++) begin
                        tags[base+i]   = tags[base+i+1];
                        stamps[base+i] = stamps[base+i+1];
                    end
                    way     = ways - 1;
                    r.alloc = 1'b1;
                end else if (replace_cfg == POL_LRU) begin
                    oldest = stamps[base];
                    for (i = 1; i < ways; i++) begin
                        if (stamps[base+i] < oldest) begin
                            oldest = stamps[base+i];
                            way    = i;
                        end
                    end
                    r.alloc = 1'b1;
                end else if (replace_cfg == POL_RANDOM) begin
                    lfsr_state = {lfsr_state[0] ^ lfsr_state[2] ^ lfsr_state[3] ^ lfsr_state[5],
                                  lfsr_state[LFSR_W-1:1]};
                    way     = lfsr_state % ways;
                    r.alloc = 1'b1;
                end
                if (r.alloc) begin
                    tags[base+way]   = r.tag;
                    stamps[base+way] = access_count;
                end
            end

            r.set_index = set[SET_IDX_W-1:0];
            r.way       = (r.hit || r.alloc) ? way[WAY_OUT_W-1:0] : '0;
            return r;
        endfunction

        function void note_access(logic op, logic [ADDR_W-1:0] addr);
            expected_lookups.push_back(predict_access(op, addr));
        endfunction

        function void check_result(logic hit, logic [SET_IDX_W-1:0] set_index,
                                   logic [TAG_W-1:0] tag, logic alloc,
                                   logic [WAY_OUT_W-1:0] way);
            lookup_result_t got, exp;
            got = '{hit, set_index, tag, alloc, way};
            if (expected_lookups.size() == 0) begin
                errors++;
                if (errors <= SHOWN_MAX)
                    $display("%0t: result with no access pending: hit=%0d set=%0d tag=%h alloc=%0d way=%0d",
                             $realtime, hit, set_index, tag, alloc, way);
            end else begin
                exp = expected_lookups.pop_front();
                if (got !== exp) begin
                    errors++;
                    if (errors <= SHOWN_MAX)
                        $display({"%0t: mismatch exp hit=%0d set=%0d tag=%h alloc=%0d way=%0d",
                                  " | got hit=%0d set=%0d tag=%h alloc=%0d way=%0d"},
                                 $realtime, exp.hit, exp.set_index, exp.tag, exp.alloc,
                                 exp.way, got.hit, got.set_index, got.tag, got.alloc, got.way);
                end
            end
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid, s_ready, s_op;
    logic [ADDR_W-1:0]     s_address;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_hit, m_allocated;
    logic [SET_IDX_W-1:0]  m_set_index;
    logic [TAG_W-1:0]      m_tag;
    logic [WAY_OUT_W-1:0]  m_way;

    set_assoc_cache_tag_lookup_top #(
        .NUM_SETS (NSETS),
        .NUM_WAYS (NWAYS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_address   (s_address),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_set_index (m_set_index),
        .m_tag       (m_tag),
        .m_allocated (m_allocated),
        .m_way       (m_way)
    );

    always #5 aclk = ~aclk;

    tag_lookup_scoreboard sb = new();

    // idle odds in percent, set per pass by the stimulus thread
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    // raised once; the receiver then holds off while hold_left counts down from LONG_HOLD
    logic hold_armed = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;
    int   stall_count = 0;

    // ------------------------------------------------------------------------
    // Result side: check every transfer, then pick m_ready for the next edge.
    // Only one nonblocking write to m_ready per edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_hit, m_set_index, m_tag, m_allocated, m_way);
        if (hold_armed && !hold_taken) begin
            hold_left  = LONG_HOLD;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer on any channel ends the run.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Valid is never dropped between back-to-back transfers, so no
    // edge sees both a low and a high write to it.
    // ------------------------------------------------------------------------
    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_access(op, addr);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // register settings per pass; pass 0 keeps the reset values
    function automatic cache_cfg_t pass_setting(int p);
        cache_cfg_t c;
        case (p)
            1:       c = '{4'd15, 3'd7, 4'd8,  POL_FIFO,     WP_ALLOCATE};    // clamped widths
            2:       c = '{4'd0,  3'd0, 4'd1,  POL_RANDOM,   WP_NO_ALLOCATE}; // fully assoc.
            3:       c = '{4'd12, 3'd6, 4'd0,  POL_RESERVED, WP_ALLOCATE};    // ways 0 -> 1
            4:       c = '{4'd4,  3'd2, 4'd15, POL_LRU,      WP_NO_ALLOCATE}; // ways capped
            5:       c = '{4'd4,  3'd2, 4'd3,  POL_FIFO,     WP_ALLOCATE};    // shrink full sets
            6:       c = '{4'd13, 3'd3, 4'd5,  POL_RANDOM,   WP_ALLOCATE};
            7:       c = '{4'd2,  3'd1, 4'd8,  POL_RANDOM,   WP_NO_ALLOCATE};
            8:       c = '{4'd5,  3'd4, 4'd6,  POL_LRU,      WP_ALLOCATE};
            default: c = '{RST_OFFSET_BITS, RST_INDEX_BITS, RST_WAYS_IN_USE, POL_LRU, WP_ALLOCATE};
        endcase
        return c;
    endfunction

    // Mostly a small pool of tags over up to four sets so sets fill, hit and evict;
    // the rest are fully random addresses to toggle every bit.
    function automatic logic [ADDR_W-1:0] pick_address(cache_cfg_t c, logic [TAG_W-1:0] tag_base);
        int ob, ib, w;
        logic [ADDR_W-1:0] tagv, setv, offs;
        ob = (c.offset_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : c.offset_bits;
        ib = (c.index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : c.index_bits;
        w  = (c.ways == 0) ? 1 : ((c.ways > NWAYS) ? NWAYS : c.ways);
        if ($urandom_range(99) < 15)
            return $urandom();
        tagv = tag_base + $urandom_range(w + 2);
        setv = $urandom_range(3);
        offs = $urandom();
        return (tagv << (ob + ib)) | ((setv & ((32'd1 << ib) - 32'd1)) << ob)
               | (offs & ((32'd1 << ob) - 32'd1));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        cache_cfg_t        c;
        logic [TAG_W-1:0]  tag_base;
        int                p, n, t;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_op      = OP_READ;
        s_address = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OFFSET_BITS;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (p = 0; p < PHASES; p++) begin
            c = pass_setting(p);
            // idling: sender rarely / receiver often, then swapped, then none
            if (p < 3) begin
                sender_idle_pct   = 6;
                receiver_idle_pct = 82;
            end else if (p < 6) begin
                sender_idle_pct   = 82;
                receiver_idle_pct = 6;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            if (p > 0) begin
                write_cfg(CFG_OFFSET_BITS,    c.offset_bits);
                write_cfg(CFG_INDEX_BITS,     {1'b0, c.index_bits});
                write_cfg(CFG_WAYS_IN_USE,    c.ways);
                write_cfg(CFG_REPLACE_POLICY, {2'b00, c.policy});
                write_cfg(CFG_WRITE_POLICY,   {3'b000, c.wpol});
                if (p == 4)
                    write_cfg(CFG_UNUSED_IDX, 4'hF);  // must not disturb anything
                cfg_valid <= 1'b0;
            end

            // receiver stalls while the sender keeps pushing, backing up the block
            if (p == HOLD_PASS)
                hold_armed = 1'b1;

            case (p)
                0: begin
                    // reset setting: 4 ways, LRU, tag from bit 12 up, set 5
                    for (t = 1; t <= 5; t++)
                        send_access(OP_READ, (t << 12) | 32'h140);  // fifth evicts way 0
                    send_access(OP_READ,  32'h0000_2140);           // hit way 1
                    send_access(OP_WRITE, 32'h0000_5140);           // hit on replaced way
                    send_access(OP_READ,  32'h0000_1140);           // miss, LRU victim
                    send_access(OP_READ,  32'h0000_0000);
                    send_access(OP_WRITE, 32'hFFFF_FFFF);
                    send_access(OP_WRITE, 32'h0000_0000);
                end
                2: begin
                    // no-allocate: write miss allocates nothing, then read fills
                    send_access(OP_WRITE, 32'h1234_5678);
                    send_access(OP_READ,  32'h1234_5678);
                    send_access(OP_WRITE, 32'h1234_5678);
                end
                3: begin
                    // reserved policy with one way: second tag in the set is dropped
                    send_access(OP_READ, 32'h0AB0_9000);
                    send_access(OP_READ, 32'h0CD0_9000);
                    send_access(OP_READ, 32'h0AB0_9000);
                end
                default: ;
            endcase

            tag_base = $urandom();
            for (n = 0; n < RANDOM_PER_PASS; n++)
                send_access(1'($urandom_range(1)), pick_address(c, tag_base));
            s_valid <= 1'b0;

            // drain before touching the registers again
            while (sb.pending() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
        end

        repeat (8) @(posedge aclk);
        if (sb.pending() != 0)
            $display("%0d results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
